[rtl/dly_pkg.sv]
package dly_pkg;

   // default sizes of the block
   localparam int DEF_CHANNELS    = 8;
   localparam int DEF_MAX_DELAY   = 65536;
   localparam int DEF_SAMPLE_BITS = 24;

   // fixed field widths
   localparam int CH_FIELD_W = 8;
   localparam int SAMPLE_W   = 24;
   localparam int TIME_W     = 16;
   localparam int RATE_W     = 18;
   localparam int CSR_DATA_W = 18;

   // register reset values
   localparam logic [RATE_W-1:0] RATE_RESET    = RATE_W'(48000);
   localparam logic [TIME_W-1:0] DEFAULT_RESET = '0;

   // time * rate / 16000 as (product >> 7) / 125, the /125 by reciprocal
   // multiply: 2^34 <= K*125 <= 2^34 + 2^7 keeps it exact for 27-bit values
   localparam int PROD_W      = TIME_W + RATE_W;
   localparam int PRE_SHIFT   = 7;
   localparam int X_W         = PROD_W - PRE_SHIFT;
   localparam int RECIP_W     = 28;
   localparam int RECIP_SHIFT = 34;
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(137438954);
   localparam int MUL_W       = X_W + RECIP_W;
   localparam int Q_W         = MUL_W - RECIP_SHIFT;

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_SET    = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_CHANNEL = 2'd1,
      ST_CLAMPED     = 2'd2
   } status_type;

   typedef enum logic {
      CSR_SAMPLE_RATE   = 1'b0,
      CSR_DEFAULT_DELAY = 1'b1
   } csr_index_type;

   // request into the time conversion unit
   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] dtime;
      logic [RATE_W-1:0] rate;
   } conv_start_type;

   // conversion result flags
   typedef struct packed {
      logic valid;
      logic clamped;
   } conv_done_type;

endpackage

[rtl/dly_if.sv]
interface dly_req_if import dly_pkg::*;;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic        [CH_FIELD_W-1:0] channel;
   logic signed [SAMPLE_W-1:0]   sample_in;
   logic        [TIME_W-1:0]     set_time;
   logic                         enable_in;

   modport source (
      output valid, action, channel, sample_in, set_time, enable_in,
      input  ready
   );
   modport sink (
      input  valid, action, channel, sample_in, set_time, enable_in,
      output ready
   );
endinterface

interface dly_rsp_if import dly_pkg::*;;
   logic                         valid;
   logic                         ready;
   logic        [CH_FIELD_W-1:0] channel_out;
   logic signed [SAMPLE_W-1:0]   sample_out;
   logic        [1:0]            status;

   modport source (
      output valid, channel_out, sample_out, status,
      input  ready
   );
   modport sink (
      input  valid, channel_out, sample_out, status,
      output ready
   );
endinterface

[rtl/dly_ram.sv]
module dly_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/dly_conv.sv]
module dly_conv import dly_pkg::*; #(
   parameter int MAX_DELAY_SAMPLES = DEF_MAX_DELAY,
   parameter int DELAY_W           = $clog2(DEF_MAX_DELAY)
) (
   input  logic               clock,
   input  logic               reset,
   input  conv_start_type     start,
   input  logic               out_ready,
   output conv_done_type      done,
   output logic [DELAY_W-1:0] delay,
   output logic               busy
);

   localparam logic [Q_W-1:0] LIMIT = Q_W'(MAX_DELAY_SAMPLES - 1);

   logic              v1_ff;
   logic              v2_ff;
   logic [PROD_W-1:0] p_ff;
   logic [MUL_W-1:0]  m_ff;
   logic              advance;
   logic [PROD_W-1:0] p_in;
   logic [MUL_W-1:0]  m_in;
   logic [Q_W-1:0]    quot;

   assign advance = !v2_ff || out_ready;
   assign busy    = v1_ff || v2_ff;

   // stage one: time * rate, stage two: reciprocal multiply for /16000
   assign p_in = PROD_W'(start.dtime) * PROD_W'(start.rate);
   assign m_in = MUL_W'(p_ff[PROD_W-1:PRE_SHIFT]) * MUL_W'(RECIP_K);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= start.valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         p_ff <= p_in;
         m_ff <= m_in;
      end
   end

   // quotient and clamp to the ring length minus one
   assign quot         = m_ff[MUL_W-1:RECIP_SHIFT];
   assign done.valid   = v2_ff;
   assign done.clamped = quot > LIMIT;
   assign delay        = (quot > LIMIT) ? DELAY_W'(LIMIT) : DELAY_W'(quot);

endmodule

[rtl/multichannel_audio_delay_line.sv]
// sample beats: one per cycle when not held off, via the read stage and output register
// set beats: via the conversion multiplier registers, the read stage and the output
//    register; the input is held off until the converted delay is applied
// a register write holds off new beats while every delay reloads
// reset is synchronous; rings need no clearing pass, a per-channel wrap flag
//    makes never-written ring words read as zero
module multichannel_audio_delay_line import dly_pkg::*; #(
   parameter int CHANNELS          = DEF_CHANNELS,
   parameter int MAX_DELAY_SAMPLES = DEF_MAX_DELAY,
   parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   dly_req_if.sink               req_bus,
   dly_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W  = $clog2(MAX_DELAY_SAMPLES);
   localparam int DEPTH  = CHANNELS * MAX_DELAY_SAMPLES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [CH_FIELD_W-1:0] CH_LIMIT = CH_FIELD_W'(CHANNELS);
   localparam logic [POS_W:0]        RING_LEN = (POS_W + 1)'(MAX_DELAY_SAMPLES);
   localparam logic [POS_W-1:0]      POS_LAST = POS_W'(MAX_DELAY_SAMPLES - 1);

   // configuration registers
   logic [RATE_W-1:0] rate_ff;
   logic [TIME_W-1:0] default_ff;
   logic              reload_pend_ff;

   // per-channel state
   logic [POS_W-1:0] wp_ff      [CHANNELS];
   logic             wrap_ff    [CHANNELS];
   logic [POS_W-1:0] delay_ff   [CHANNELS];
   logic             enabled_ff [CHANNELS];

   // set beat waiting on the conversion
   logic                  set_pend_ff;
   logic [CH_FIELD_W-1:0] set_ch_ff;
   logic                  set_en_ff;

   // memory read stage
   logic                       s1_valid_ff;
   logic [CH_FIELD_W-1:0]      s1_ch_ff;
   status_type                 s1_status_ff;
   logic                       s1_from_mem_ff;
   logic signed [SAMPLE_W-1:0] s1_direct_ff;

   // output register
   logic                       out_valid_ff;
   logic [CH_FIELD_W-1:0]      out_ch_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff;
   status_type                 out_status_ff;

   logic                          busy;
   logic                          conv_busy;
   logic                          s1_move;
   logic                          s1_free;
   logic                          accept;
   logic                          is_set;
   logic                          in_range;
   logic [CH_W-1:0]               idx;
   logic [POS_W-1:0]              cur_wp;
   logic [POS_W-1:0]              cur_d;
   logic                          cur_wrap;
   logic                          cur_en;
   logic                          active;
   logic                          d_zero;
   logic                          rd_ok;
   logic [POS_W:0]                rp_wide;
   logic [POS_W-1:0]              rp;
   logic [ADDR_W-1:0]             base;
   logic                          mem_wr;
   logic                          mem_rd;
   logic [SAMPLE_BITS-1:0]        packed_in;
   logic signed [SAMPLE_BITS-1:0] packed_signed;
   logic signed [SAMPLE_BITS-1:0] rd_signed;
   logic [SAMPLE_BITS-1:0]        rd_data;
   logic signed [SAMPLE_W-1:0]    roundtrip;
   logic signed [SAMPLE_W-1:0]    direct_in;
   conv_start_type                conv_start;
   conv_done_type                 conv_done;
   logic [POS_W-1:0]              conv_delay;
   logic                          conv_out_ready;
   logic                          set_fire;
   logic                          reload_apply;
   logic                          set_accept;

   // handshake
   assign busy          = reload_pend_ff || set_pend_ff || conv_busy;
   assign s1_move       = !out_valid_ff || rsp_bus.ready;
   assign s1_free       = !s1_valid_ff || s1_move;
   assign req_bus.ready = !busy && s1_free;
   assign accept        = req_bus.valid && req_bus.ready;

   // decode and per-channel lookup
   assign is_set   = req_bus.action == ACT_SET;
   assign in_range = req_bus.channel < CH_LIMIT;
   assign idx      = req_bus.channel[CH_W-1:0];
   assign cur_wp   = wp_ff[idx];
   assign cur_d    = delay_ff[idx];
   assign cur_wrap = wrap_ff[idx];
   assign cur_en   = enabled_ff[idx];
   assign active   = accept && !is_set && in_range && cur_en;

   // read position behind the write position, modulo the ring length
   assign rp_wide = (cur_wp >= cur_d) ? ((POS_W + 1)'(cur_wp) - (POS_W + 1)'(cur_d))
                                      : ((POS_W + 1)'(cur_wp) + RING_LEN - (POS_W + 1)'(cur_d));
   assign rp      = rp_wide[POS_W-1:0];
   assign d_zero  = cur_d == '0;
   assign rd_ok   = cur_wrap || (cur_d <= cur_wp);

   // memory access
   assign base   = ADDR_W'(idx) * ADDR_W'(MAX_DELAY_SAMPLES);
   assign mem_wr = active;
   assign mem_rd = active && !d_zero && rd_ok;

   assign packed_signed = SAMPLE_BITS'(req_bus.sample_in);
   assign packed_in     = packed_signed;
   assign roundtrip     = SAMPLE_W'(packed_signed);
   assign rd_signed     = rd_data;

   dly_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (base + ADDR_W'(cur_wp)),
      .wr_data (packed_in),
      .rd_en   (mem_rd),
      .rd_addr (base + ADDR_W'(rp)),
      .rd_data (rd_data)
   );

   // sample value when the memory is not read
   always_comb begin
      if (in_range && cur_en) begin
         direct_in = d_zero ? roundtrip : '0;
      end else begin
         direct_in = req_bus.sample_in;
      end
   end

   // time conversion, shared by set beats and register reloads
   assign set_accept       = accept && is_set && in_range;
   assign conv_start.valid = set_accept || reload_pend_ff;
   assign conv_start.dtime = reload_pend_ff ? default_ff : req_bus.set_time;
   assign conv_start.rate  = rate_ff;
   assign conv_out_ready   = !set_pend_ff || s1_free;
   assign set_fire         = conv_done.valid && set_pend_ff && s1_free;
   assign reload_apply     = conv_done.valid && !set_pend_ff;

   dly_conv #(
      .MAX_DELAY_SAMPLES (MAX_DELAY_SAMPLES),
      .DELAY_W           (POS_W)
   ) u_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (conv_start),
      .out_ready (conv_out_ready),
      .done      (conv_done),
      .delay     (conv_delay),
      .busy      (conv_busy)
   );

   // configuration registers and reload request
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff        <= RATE_RESET;
         default_ff     <= DEFAULT_RESET;
         reload_pend_ff <= 1'b0;
      end else begin
         reload_pend_ff <= csr_we || (reload_pend_ff && !conv_start.valid);
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_RATE:   rate_ff    <= csr_wdata[RATE_W-1:0];
               CSR_DEFAULT_DELAY: default_ff <= csr_wdata[TIME_W-1:0];
               default:           rate_ff    <= rate_ff;
            endcase
         end
      end
   end

   // per-channel positions, delays and enables
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i]      <= '0;
            wrap_ff[i]    <= 1'b0;
            delay_ff[i]   <= '0;
            enabled_ff[i] <= 1'b1;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (active && idx == CH_W'(i)) begin
               wp_ff[i] <= (cur_wp == POS_LAST) ? '0 : cur_wp + POS_W'(1);
               if (cur_wp == POS_LAST) begin
                  wrap_ff[i] <= 1'b1;
               end
            end
            if (set_fire && set_ch_ff[CH_W-1:0] == CH_W'(i)) begin
               delay_ff[i]   <= conv_delay;
               enabled_ff[i] <= set_en_ff;
            end
            if (reload_apply) begin
               delay_ff[i] <= conv_delay;
            end
         end
      end
   end

   // set beat bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         set_pend_ff <= 1'b0;
      end else if (set_accept) begin
         set_pend_ff <= 1'b1;
      end else if (set_fire) begin
         set_pend_ff <= 1'b0;
      end
      if (set_accept) begin
         set_ch_ff <= req_bus.channel;
         set_en_ff <= req_bus.enable_in;
      end
   end

   // memory read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if ((accept && !set_accept) || set_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
      if (set_fire) begin
         s1_ch_ff       <= set_ch_ff;
         s1_status_ff   <= conv_done.clamped ? ST_CLAMPED : ST_OK;
         s1_from_mem_ff <= 1'b0;
         s1_direct_ff   <= '0;
      end else if (accept && !set_accept) begin
         s1_ch_ff       <= req_bus.channel;
         s1_status_ff   <= in_range ? ST_OK : ST_BAD_CHANNEL;
         s1_from_mem_ff <= mem_rd;
         s1_direct_ff   <= is_set ? '0 : direct_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_move) begin
         out_valid_ff <= s1_valid_ff;
      end
      if (s1_move && s1_valid_ff) begin
         out_ch_ff     <= s1_ch_ff;
         out_status_ff <= s1_status_ff;
         out_sample_ff <= s1_from_mem_ff ? SAMPLE_W'(rd_signed) : s1_direct_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.channel_out = out_ch_ff;
   assign rsp_bus.sample_out  = out_sample_ff;
   assign rsp_bus.status      = out_status_ff;

endmodule

[tb/sv/delay_line_check.sv]
module delay_line_check import dly_pkg::*; #(
   parameter int CHANNELS          = DEF_CHANNELS,
   parameter int MAX_DELAY_SAMPLES = DEF_MAX_DELAY,
   parameter int SAMPLE_BITS       = DEF_SAMPLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   dly_req_if                    req_mon,
   dly_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding,
   output int                    beats_checked,
   output int                    set_beats,
   output int                    clamp_count,
   output int                    bad_channel_count
);

   typedef struct packed {
      logic [CH_FIELD_W-1:0] channel;
      logic [SAMPLE_W-1:0]   sample;
      status_type            status;
   } result_beat_type;

   // own copy of the block state
   bit   [SAMPLE_W-1:0] ring_words [longint unsigned];
   int unsigned         write_pos [CHANNELS];
   int unsigned         delay_of [CHANNELS];
   bit                  enabled [CHANNELS];
   logic [RATE_W-1:0]   rate_reg;
   logic [TIME_W-1:0]   default_reg;
   result_beat_type     predicted_outputs [$];

   int fails    = 0;
   int pending  = 0;
   int checked  = 0;
   int sets     = 0;
   int clamps   = 0;
   int bad_chan = 0;

   assign fail_count        = fails;
   assign outstanding       = pending;
   assign beats_checked     = checked;
   assign set_beats         = sets;
   assign clamp_count       = clamps;
   assign bad_channel_count = bad_chan;

   // floor(time * rate / 16000), clamped to the ring size minus one
   function automatic int unsigned delay_samples(input logic [TIME_W-1:0] t,
                                                 input logic [RATE_W-1:0] rate,
                                                 output bit clamped);
      longint unsigned n;
      n = (64'(t) * 64'(rate)) / 64'd16000;
      clamped = (n > longint'(MAX_DELAY_SAMPLES - 1));
      return clamped ? MAX_DELAY_SAMPLES - 1 : int'(n);
   endfunction

   // every channel delay from the default time at the current rate
   task automatic reload_delays();
      bit          c;
      int unsigned d;
      d = delay_samples(default_reg, rate_reg, c);
      foreach (delay_of[i]) delay_of[i] = d;
   endtask

   // one request beat through the delay line, returns its result beat
   function automatic result_beat_type delay_line_step(input logic                  action,
                                                       input logic [CH_FIELD_W-1:0] ch,
                                                       input logic [SAMPLE_W-1:0]   s,
                                                       input logic [TIME_W-1:0]     t,
                                                       input logic                  en);
      result_beat_type r;
      bit              c;
      longint unsigned base;
      int unsigned     rp;
      logic signed [31:0] word;
      r.channel = ch;
      r.sample  = '0;
      r.status  = ST_OK;
      if (ch >= CHANNELS) begin
         r.status = ST_BAD_CHANNEL;
         if (action == ACT_SAMPLE) r.sample = s;
      end else if (action == ACT_SET) begin
         delay_of[ch] = delay_samples(t, rate_reg, c);
         enabled[ch]  = en;
         if (c) r.status = ST_CLAMPED;
      end else if (!enabled[ch]) begin
         r.sample = s;
      end else begin
         base = longint'(ch) * MAX_DELAY_SAMPLES;
         rp   = (write_pos[ch] + MAX_DELAY_SAMPLES - delay_of[ch]) % MAX_DELAY_SAMPLES;
         // memory word keeps SAMPLE_BITS bits, sign-extended on read
         word = {{8{s[SAMPLE_W-1]}}, s};
         word = (word <<< (32 - SAMPLE_BITS)) >>> (32 - SAMPLE_BITS);
         ring_words[base + write_pos[ch]] = word[SAMPLE_W-1:0];
         r.sample = ring_words.exists(base + rp) ? ring_words[base + rp] : '0;
         write_pos[ch] = (write_pos[ch] + 1) % MAX_DELAY_SAMPLES;
      end
      return r;
   endfunction

   // watch every handshake at the rising edge
   always @(posedge clock) begin
      result_beat_type exp_beat;
      if (reset) begin
         ring_words.delete();
         predicted_outputs.delete();
         rate_reg    = RATE_RESET;
         default_reg = DEFAULT_RESET;
         foreach (write_pos[i]) begin
            write_pos[i] = 0;
            enabled[i]   = 1'b1;
         end
         reload_delays();
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_SAMPLE_RATE) rate_reg = csr_wdata[RATE_W-1:0];
            else default_reg = csr_wdata[TIME_W-1:0];
            reload_delays();
         end

         // accepted request beat
         if (req_mon.valid && req_mon.ready) begin
            exp_beat = delay_line_step(req_mon.action, req_mon.channel, req_mon.sample_in,
                                       req_mon.set_time, req_mon.enable_in);
            predicted_outputs.push_back(exp_beat);
            if (req_mon.action == ACT_SET) sets++;
            if (exp_beat.status == ST_CLAMPED) clamps++;
            if (exp_beat.status == ST_BAD_CHANNEL) bad_chan++;
         end

         // accepted result beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("result beat with nothing predicted: channel_out %0d",
                      rsp_mon.channel_out);
               fails++;
            end else begin
               exp_beat = predicted_outputs.pop_front();
               checked++;
               if (rsp_mon.channel_out !== exp_beat.channel) begin
                  $error("channel_out expected %0d actual %0d",
                         exp_beat.channel, rsp_mon.channel_out);
                  fails++;
               end
               if (rsp_mon.sample_out !== exp_beat.sample) begin
                  $error("sample_out expected %0d actual %0d",
                         $signed(exp_beat.sample), $signed(rsp_mon.sample_out));
                  fails++;
               end
               if (rsp_mon.status !== exp_beat.status) begin
                  $error("status expected %0d actual %0d", exp_beat.status, rsp_mon.status);
                  fails++;
               end
            end
         end
      end
      pending = predicted_outputs.size();
   end

endmodule

[tb/sv/tb.sv]
module tb;
   import dly_pkg::*;

   localparam int CHANNELS     = DEF_CHANNELS;
   localparam int PHASE_BEATS  = 160;
   localparam int LONG_HOLD    = 250;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      action_type                 action;
      logic        [CH_FIELD_W-1:0] channel;
      logic signed [SAMPLE_W-1:0] sample;
      logic        [TIME_W-1:0]   dtime;
      logic                       enable;
   } request_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count, outstanding, beats_checked, set_beats, clamp_count, bad_channel_count;
   int settings_used = 0;
   bit stall_request = 1'b0;

   dly_req_if req_bus ();
   dly_rsp_if rsp_bus ();

   multichannel_audio_delay_line dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   delay_line_check delay_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_bus),
      .rsp_mon           (rsp_bus),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .beats_checked     (beats_checked),
      .set_beats         (set_beats),
      .clamp_count       (clamp_count),
      .bad_channel_count (bad_channel_count)
   );

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // watchdog
   initial begin
      #(8 * 300000);
      $display("FAIL multichannel_audio_delay_line");
      $finish;
   end

   function automatic request_beat_type beat_of(input action_type a, input int ch,
                                                input int s, input int t, input bit en);
      request_beat_type b;
      b.action  = a;
      b.channel = CH_FIELD_W'(ch);
      b.sample  = SAMPLE_W'(s);
      b.dtime   = TIME_W'(t);
      b.enable  = en;
      return b;
   endfunction

   // mostly in-range samples, some sets with short delays, a little noise
   function automatic request_beat_type random_beat();
      request_beat_type b;
      int               roll;
      b.action  = ($urandom_range(0, 99) < 15) ? ACT_SET : ACT_SAMPLE;
      b.channel = ($urandom_range(0, 99) < 8) ? CH_FIELD_W'($urandom_range(CHANNELS, 255))
                                              : CH_FIELD_W'($urandom_range(0, CHANNELS - 1));
      b.sample  = SAMPLE_W'($urandom);
      roll      = $urandom_range(0, 99);
      if (roll < 70) b.dtime = TIME_W'($urandom_range(0, 6));
      else if (roll < 90) b.dtime = TIME_W'($urandom);
      else b.dtime = $urandom_range(0, 1) ? '1 : '0;
      b.enable  = ($urandom_range(0, 99) < 85);
      return b;
   endfunction

   // drive one beat at the falling edge and hold it until accepted
   task automatic send_beat(input request_beat_type b);
      @(negedge clock);
      req_bus.valid      = 1'b1;
      req_bus.action     = b.action;
      req_bus.channel    = b.channel;
      req_bus.sample_in  = b.sample;
      req_bus.set_time   = b.dtime;
      req_bus.enable_in  = b.enable;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // let everything drain, then move to a new rate and default delay
   task automatic configure_phase(input logic [RATE_W-1:0] rate, input logic [TIME_W-1:0] dflt);
      idle_cycles(1);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_register(CSR_SAMPLE_RATE, CSR_DATA_W'(rate));
      write_register(CSR_DEFAULT_DELAY, {2'($urandom), dflt});
      settings_used++;
   endtask

   // bursts of random length separated by random gaps
   task automatic send_random(input int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < count; i++) begin
            send_beat(random_beat());
            sent++;
         end
         idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
   endtask

   // result receiver: changing stall pattern, one long hold on request
   initial begin
      int hold_left;
      int pattern;
      int pattern_left;
      hold_left    = 0;
      pattern_left = 0;
      pattern      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern      = $urandom_range(0, 2);
               pattern_left = $urandom_range(8, 64);
            end
            pattern_left--;
            case (pattern)
               0: rsp_bus.ready = 1'b1;
               1: rsp_bus.ready = ($urandom_range(0, 3) != 0);
               default: rsp_bus.ready = ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [RATE_W-1:0] rates [6];
      logic [TIME_W-1:0] defaults [6];
      rates    = '{18'd8000, 18'd192000, 18'd0, 18'd262143, 18'd44100, 18'd48000};
      defaults = '{16'd65535, 16'd1, 16'd100, 16'd65535, 16'd3, 16'd0};

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_SAMPLE_RATE;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_SAMPLE;
      req_bus.channel    = '0;
      req_bus.sample_in  = '0;
      req_bus.set_time   = '0;
      req_bus.enable_in  = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset rate and zero delay first
      send_beat(beat_of(ACT_SAMPLE, 0, 8388607, 0, 1));
      send_beat(beat_of(ACT_SAMPLE, 0, -8388608, 0, 1));
      send_beat(beat_of(ACT_SAMPLE, 0, 0, 65535, 0));
      // channels out of range on both kinds of beat
      send_beat(beat_of(ACT_SAMPLE, CHANNELS, 123, 0, 1));
      send_beat(beat_of(ACT_SAMPLE, 255, -1, 0, 1));
      send_beat(beat_of(ACT_SET, 255, 0, 5, 1));
      // three-sample delay on channel 1
      send_beat(beat_of(ACT_SET, 1, 0, 1, 1));
      for (int i = 1; i <= 5; i++) send_beat(beat_of(ACT_SAMPLE, 1, i, 0, 1));
      // bypassed channel leaves its ring alone
      send_beat(beat_of(ACT_SET, 2, 0, 5, 0));
      send_beat(beat_of(ACT_SAMPLE, 2, 777, 0, 1));
      send_beat(beat_of(ACT_SAMPLE, 2, -777, 0, 1));
      // largest delay that fits, then just over it, then the top time
      send_beat(beat_of(ACT_SET, 3, 0, 21845, 1));
      send_beat(beat_of(ACT_SAMPLE, 3, 42, 0, 1));
      send_beat(beat_of(ACT_SET, 4, 0, 21846, 1));
      send_beat(beat_of(ACT_SET, 5, 0, 65535, 1));
      // zero time, and re-enabling the bypassed channel
      send_beat(beat_of(ACT_SET, 6, 0, 0, 1));
      send_beat(beat_of(ACT_SAMPLE, 6, -5, 0, 1));
      send_beat(beat_of(ACT_SET, 2, 0, 0, 1));
      send_beat(beat_of(ACT_SAMPLE, 2, 9, 0, 1));
      send_beat(beat_of(ACT_SAMPLE, 7, 8388607, 0, 1));

      // random phases, one per register setting
      foreach (rates[p]) begin
         configure_phase(rates[p], defaults[p]);
         if (p == 1) stall_request = 1'b1;
         send_random(PHASE_BEATS);
      end

      idle_cycles(1);
      while (outstanding != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("checked %0d result beats over %0d register settings", beats_checked,
               settings_used);
      $display("%0d set beats, %0d clamped delays, %0d out-of-range channels", set_beats,
               clamp_count, bad_channel_count);
      if (fail_count == 0) begin
         $display("PASS multichannel_audio_delay_line");
      end else begin
         $display("FAIL multichannel_audio_delay_line");
      end
      $finish;
   end

endmodule

[multichannel_audio_delay_line.f]
rtl/dly_pkg.sv
rtl/dly_if.sv
rtl/dly_ram.sv
rtl/dly_conv.sv
rtl/multichannel_audio_delay_line.sv
tb/sv/delay_line_check.sv
tb/sv/tb.sv
